// File: sv/cmdu_pkg.sv
// shared types and constants of the complex multiply / divide unit
// operation and status codes, pipeline control struct, width helpers
// no dependencies
package cmdu_pkg;

	localparam int DataWidthDef = 16;
	localparam int FracBitsDef  = 12;

	localparam logic [1:0] FUNC_MUL   = 2'd0;
	localparam logic [1:0] FUNC_DIV   = 2'd1;
	localparam logic [1:0] FUNC_RECIP = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_SAT = 2'd1,
		STAT_DZ  = 2'd2
	} status_t;

	// per-item control that travels along the pipe
	typedef struct packed {
		logic is_mul;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
	} ctl_t;

	// width of one product term, wide enough for the scaled reciprocal operand
	function automatic int prod_width(input int w, input int f);
		prod_width = (2 * w > w + f + 1) ? 2 * w : w + f + 1;
	endfunction

	// magnitude of a two-term sum
	function automatic int mag_width(input int w, input int f);
		mag_width = prod_width(w, f);
	endfunction

	// divider remainder: holds mag << f and den << w
	function automatic int rem_width(input int w, input int f);
		int nw;
		nw = mag_width(w, f) + f;
		rem_width = ((nw > 3 * w) ? nw : 3 * w) + 1;
	endfunction

	function automatic int pad8(input int n);
		pad8 = ((n + 7) / 8) * 8;
	endfunction

endpackage

// File: sv/complex_mul_div_unit_top.sv
// complex multiply / divide / reciprocal unit on signed fixed point, top level
// front end, one restoring-division stage per quotient bit, output stage; uses cmdu_pkg
//
//  channel | dir | beat payload
//  s_*     | in  | tdata: x_re, x_im, y_re, y_im; tuser: func
//  m_*     | out | tdata: res_re, res_im; tuser: status
//
// three front stages, one divider stage per quotient bit, one output register;
// one beat per cycle sustained while the output beat is taken.
// the whole pipe advances together; it holds while the output beat is not taken.
// reset clears only the valid bits.
module complex_mul_div_unit_top #(
	parameter int DATA_WIDTH = cmdu_pkg::DataWidthDef,
	parameter int FRAC_BITS  = cmdu_pkg::FracBitsDef
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// x_re, x_im, y_re, y_im from the lowest bit up
	input  logic [cmdu_pkg::pad8(4*DATA_WIDTH)-1:0]   s_tdata,
	// func
	input  logic [7:0]                                s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// res_re, res_im from the lowest bit up
	output logic [cmdu_pkg::pad8(2*DATA_WIDTH)-1:0]   m_tdata,
	// status
	output logic [7:0]                                m_tuser
);
	localparam int W  = DATA_WIDTH;
	localparam int RW = cmdu_pkg::rem_width(W, FRAC_BITS);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic                 v_c   [W+1];
	cmdu_pkg::ctl_t       ctl_c [W+1];
	logic [W-1:0]         qr_c  [W+1];
	logic [W-1:0]         qi_c  [W+1];
	logic [RW-1:0]        rr_c  [W+1];
	logic [RW-1:0]        ri_c  [W+1];
	logic [2*W-1:0]       den_c [W+1];

	cmdu_front #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid && en),
		.func(s_tuser[1:0]),
		.x_re(s_tdata[W-1:0]),
		.x_im(s_tdata[2*W-1:W]),
		.y_re(s_tdata[3*W-1:2*W]),
		.y_im(s_tdata[4*W-1:3*W]),
		.valid_s3(v_c[0]), .ctl_s3(ctl_c[0]),
		.q_re_s3(qr_c[0]), .q_im_s3(qi_c[0]),
		.rem_re_s3(rr_c[0]), .rem_im_s3(ri_c[0]),
		.den_s3(den_c[0])
	);

	// quotient bits from the top down
	for (genvar j = 0; j < W; j++) begin : g_div
		cmdu_div_stage #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .BIT_POS(W-1-j)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(v_c[j]), .ctl_in(ctl_c[j]),
			.q_re_in(qr_c[j]), .q_im_in(qi_c[j]),
			.rem_re_in(rr_c[j]), .rem_im_in(ri_c[j]),
			.den_in(den_c[j]),
			.valid_s(v_c[j+1]), .ctl_s(ctl_c[j+1]),
			.q_re_s(qr_c[j+1]), .q_im_s(qi_c[j+1]),
			.rem_re_s(rr_c[j+1]), .rem_im_s(ri_c[j+1]),
			.den_s(den_c[j+1])
		);
	end

	cmdu_out #(.DATA_WIDTH(W)) u_out (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_in(v_c[W]), .ctl_in(ctl_c[W]),
		.q_re_in(qr_c[W]), .q_im_in(qi_c[W]),
		.m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

// File: sv/cmdu_front.sv
// front end of the complex unit: products, sums, magnitudes, range check
// three register stages; depends on cmdu_pkg
module cmdu_front #(
	parameter int DATA_WIDTH = cmdu_pkg::DataWidthDef,
	parameter int FRAC_BITS  = cmdu_pkg::FracBitsDef
) (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     en,
	input  logic                                                     in_valid,
	input  logic [1:0]                                               func,
	input  logic signed [DATA_WIDTH-1:0]                             x_re,
	input  logic signed [DATA_WIDTH-1:0]                             x_im,
	input  logic signed [DATA_WIDTH-1:0]                             y_re,
	input  logic signed [DATA_WIDTH-1:0]                             y_im,
	output logic                                                     valid_s3,
	output cmdu_pkg::ctl_t                                           ctl_s3,
	output logic [DATA_WIDTH-1:0]                                    q_re_s3,
	output logic [DATA_WIDTH-1:0]                                    q_im_s3,
	output logic [cmdu_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0]   rem_re_s3,
	output logic [cmdu_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0]   rem_im_s3,
	output logic [2*DATA_WIDTH-1:0]                                  den_s3
);
	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = cmdu_pkg::prod_width(W, F);
	localparam int SW = PW + 1;
	localparam int MW = cmdu_pkg::mag_width(W, F);
	localparam int DW = 2 * W;
	localparam int RW = cmdu_pkg::rem_width(W, F);

	// stage 1: products
	logic signed [2*W-1:0] m_ac, m_bd, m_ad, m_bc, m_cc, m_dd;
	logic                  is_mul, is_recip;
	logic signed [PW-1:0]  ac_s1, bd_s1, ad_s1, bc_s1;
	logic signed [2*W-1:0] cc_s1, dd_s1;
	logic                  is_mul_s1, valid_s1;

	assign m_ac = x_re * y_re;
	assign m_bd = x_im * y_im;
	assign m_ad = x_re * y_im;
	assign m_bc = x_im * y_re;
	assign m_cc = y_re * y_re;
	assign m_dd = y_im * y_im;
	assign is_mul   = (func == cmdu_pkg::FUNC_MUL);
	assign is_recip = func[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// reciprocal takes x as 1.0 and 0
			ac_s1     <= is_recip ? (PW'(y_re) <<< F) : PW'(m_ac);
			bd_s1     <= is_recip ? '0 : PW'(m_bd);
			ad_s1     <= is_recip ? (PW'(y_im) <<< F) : PW'(m_ad);
			bc_s1     <= is_recip ? '0 : PW'(m_bc);
			cc_s1     <= m_cc;
			dd_s1     <= m_dd;
			is_mul_s1 <= is_mul;
		end
	end

	// stage 2: sums, sign and magnitude, divisor norm
	logic signed [SW-1:0] re_sum, im_sum;
	logic [MW-1:0]        mag_re_s2, mag_im_s2;
	logic                 neg_re_s2, neg_im_s2, is_mul_s2, valid_s2;
	logic [DW-1:0]        den_s2;

	always_comb begin
		if (is_mul_s1) begin
			re_sum = SW'(ac_s1) - SW'(bd_s1);
			im_sum = SW'(ad_s1) + SW'(bc_s1);
		end else begin
			re_sum = SW'(ac_s1) + SW'(bd_s1);
			im_sum = SW'(bc_s1) - SW'(ad_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_re_s2 <= re_sum[SW-1];
			neg_im_s2 <= im_sum[SW-1];
			mag_re_s2 <= re_sum[SW-1] ? MW'(-re_sum) : MW'(re_sum);
			mag_im_s2 <= im_sum[SW-1] ? MW'(-im_sum) : MW'(im_sum);
			den_s2    <= $unsigned(cc_s1) + $unsigned(dd_s1);
			is_mul_s2 <= is_mul_s1;
		end
	end

	// stage 3: product scaling, dividend alignment, quotient range check
	logic [MW-1:0] sh_re, sh_im;
	logic [RW-1:0] n_re, n_im, den_top;
	cmdu_pkg::ctl_t ctl_n;

	always_comb begin
		sh_re   = mag_re_s2 >> F;
		sh_im   = mag_im_s2 >> F;
		n_re    = RW'(mag_re_s2) << F;
		n_im    = RW'(mag_im_s2) << F;
		den_top = RW'(den_s2) << W;
		ctl_n.is_mul = is_mul_s2;
		ctl_n.dz     = !is_mul_s2 && (den_s2 == '0);
		ctl_n.neg_re = neg_re_s2;
		ctl_n.neg_im = neg_im_s2;
		// quotient of more than W bits cannot fit
		ctl_n.ovf_re = is_mul_s2 ? (|sh_re[MW-1:W]) : (n_re >= den_top);
		ctl_n.ovf_im = is_mul_s2 ? (|sh_im[MW-1:W]) : (n_im >= den_top);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3    <= ctl_n;
			q_re_s3   <= is_mul_s2 ? sh_re[W-1:0] : '0;
			q_im_s3   <= is_mul_s2 ? sh_im[W-1:0] : '0;
			rem_re_s3 <= n_re;
			rem_im_s3 <= n_im;
			den_s3    <= den_s2;
		end
	end

endmodule

// File: sv/cmdu_div_stage.sv
// one restoring-division stage: decides quotient bit BIT_POS for both parts
// depends on cmdu_pkg
module cmdu_div_stage #(
	parameter int DATA_WIDTH = cmdu_pkg::DataWidthDef,
	parameter int FRAC_BITS  = cmdu_pkg::FracBitsDef,
	parameter int BIT_POS    = 0
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   en,
	input  logic                                                   valid_in,
	input  cmdu_pkg::ctl_t                                         ctl_in,
	input  logic [DATA_WIDTH-1:0]                                  q_re_in,
	input  logic [DATA_WIDTH-1:0]                                  q_im_in,
	input  logic [cmdu_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0] rem_re_in,
	input  logic [cmdu_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0] rem_im_in,
	input  logic [2*DATA_WIDTH-1:0]                                den_in,
	output logic                                                   valid_s,
	output cmdu_pkg::ctl_t                                         ctl_s,
	output logic [DATA_WIDTH-1:0]                                  q_re_s,
	output logic [DATA_WIDTH-1:0]                                  q_im_s,
	output logic [cmdu_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0] rem_re_s,
	output logic [cmdu_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0] rem_im_s,
	output logic [2*DATA_WIDTH-1:0]                                den_s
);
	localparam int RW = cmdu_pkg::rem_width(DATA_WIDTH, FRAC_BITS);

	logic [RW-1:0]         dk;
	logic                  take_re, take_im;
	logic [DATA_WIDTH-1:0] q_re_n, q_im_n;

	always_comb begin
		dk      = RW'(den_in) << BIT_POS;
		take_re = !ctl_in.is_mul && (rem_re_in >= dk);
		take_im = !ctl_in.is_mul && (rem_im_in >= dk);
		q_re_n  = q_re_in;
		q_im_n  = q_im_in;
		q_re_n[BIT_POS] = q_re_in[BIT_POS] | take_re;
		q_im_n[BIT_POS] = q_im_in[BIT_POS] | take_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s    <= ctl_in;
			q_re_s   <= q_re_n;
			q_im_s   <= q_im_n;
			rem_re_s <= take_re ? rem_re_in - dk : rem_re_in;
			rem_im_s <= take_im ? rem_im_in - dk : rem_im_in;
			den_s    <= den_in;
		end
	end

endmodule

// File: sv/cmdu_out.sv
// output stage: saturation, sign restore, status and the result register
// depends on cmdu_pkg
module cmdu_out #(
	parameter int DATA_WIDTH = cmdu_pkg::DataWidthDef
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           valid_in,
	input  cmdu_pkg::ctl_t                                 ctl_in,
	input  logic [DATA_WIDTH-1:0]                          q_re_in,
	input  logic [DATA_WIDTH-1:0]                          q_im_in,
	output logic                                           m_tvalid,
	output logic [cmdu_pkg::pad8(2*DATA_WIDTH)-1:0]        m_tdata,
	output logic [7:0]                                     m_tuser
);
	localparam int W  = DATA_WIDTH;
	localparam int OW = cmdu_pkg::pad8(2 * W);
	localparam logic [W-1:0] LimPos = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] LimNeg = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]       mr, mi, vr, vi;
	logic               sat_re, sat_im;
	cmdu_pkg::status_t  st;

	always_comb begin
		sat_re = ctl_in.ovf_re || (q_re_in > (ctl_in.neg_re ? LimNeg : LimPos));
		sat_im = ctl_in.ovf_im || (q_im_in > (ctl_in.neg_im ? LimNeg : LimPos));
		mr = sat_re ? (ctl_in.neg_re ? LimNeg : LimPos) : q_re_in;
		mi = sat_im ? (ctl_in.neg_im ? LimNeg : LimPos) : q_im_in;
		vr = ctl_in.neg_re ? -mr : mr;
		vi = ctl_in.neg_im ? -mi : mi;
		if (ctl_in.dz) begin
			vr = '0;
			vi = '0;
			st = cmdu_pkg::STAT_DZ;
		end else if (sat_re || sat_im) begin
			st = cmdu_pkg::STAT_SAT;
		end else begin
			st = cmdu_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OW'({vi, vr});
			m_tuser <= {6'd0, st};
		end
	end

endmodule

// File: tb/tb_complex_mul_div_unit_top.sv
// self-checking bench for complex_mul_div_unit_top: random and directed complex
// multiply / divide / reciprocal beats checked against a bit-exact predictor
// depends on cmdu_pkg and the top level
`timescale 1ns / 100ps

class cplx_scoreboard;
	logic [15:0]        want_re[$];
	logic [15:0]        want_im[$];
	cmdu_pkg::status_t  want_st[$];
	int                 errors;
	int                 checked;
	int                 sat_seen;
	int                 dz_seen;

	// saturate a sign/magnitude value to 16 bits
	function automatic logic [15:0] clamp(bit neg, logic [127:0] mag, ref bit sat);
		logic [127:0] lim;
		logic [127:0] m;
		lim = neg ? 128'd32768 : 128'd32767;
		m = mag;
		if (m > lim) begin
			m = lim;
			sat = 1;
		end
		return neg ? 16'(-m) : 16'(m);
	endfunction

	// floor(m * 2^12 / den); operands are small enough that no cap is reached
	function automatic logic [127:0] frac_div(logic [127:0] m, logic [127:0] den);
		return (m << 12) / den;
	endfunction

	function void note_input(logic [1:0] op, logic signed [15:0] xr, logic signed [15:0] xi,
			logic signed [15:0] yr, logic signed [15:0] yi);
		longint a, b, c, d, sr, si, den;
		bit sat;
		logic [127:0] mr, mi;
		sat = 0;
		a = xr; b = xi; c = yr; d = yi;
		if (op == cmdu_pkg::FUNC_MUL) begin
			sr = a * c - b * d;
			si = a * d + b * c;
			mr = (sr < 0) ? (-sr) >> 12 : sr >> 12;
			mi = (si < 0) ? (-si) >> 12 : si >> 12;
		end else begin
			den = c * c + d * d;
			if (den == 0) begin
				want_re.push_back('0);
				want_im.push_back('0);
				want_st.push_back(cmdu_pkg::STAT_DZ);
				return;
			end
			if (op[1]) begin
				a = 4096;
				b = 0;
			end
			sr = a * c + b * d;
			si = b * c - a * d;
			mr = frac_div((sr < 0) ? -sr : sr, den);
			mi = frac_div((si < 0) ? -si : si, den);
		end
		want_re.push_back(clamp(sr < 0, mr, sat));
		want_im.push_back(clamp(si < 0, mi, sat));
		want_st.push_back(sat ? cmdu_pkg::STAT_SAT : cmdu_pkg::STAT_OK);
	endfunction

	task report(string what, int got, int exp);
		$display("mismatch %s: got %0h, expected %0h", what, got, exp);
		errors++;
	endtask

	task check_result(logic [15:0] re, logic [15:0] im, logic [1:0] st);
		if (want_st.size() == 0) begin
			report("unexpected beat", st, 0);
			return;
		end
		if (re !== want_re[0]) report("res_re", re, want_re[0]);
		if (im !== want_im[0]) report("res_im", im, want_im[0]);
		if (st !== want_st[0]) report("status", st, want_st[0]);
		if (want_st[0] == cmdu_pkg::STAT_SAT) sat_seen++;
		if (want_st[0] == cmdu_pkg::STAT_DZ) dz_seen++;
		void'(want_re.pop_front());
		void'(want_im.pop_front());
		void'(want_st.pop_front());
		checked++;
	endtask
endclass

module tb_complex_mul_div_unit_top;
	localparam int Limit = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [7:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [7:0]  m_tuser;

	cplx_scoreboard sb;
	int  idle_cycles = 0;

	complex_mul_div_unit_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [15:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			3: return 16'($urandom_range(0, 16'h1fff)) - 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	// one beat: held on the falling edge until a rising edge accepts it
	task send(logic [1:0] op, logic [15:0] xr, logic [15:0] xi, logic [15:0] yr,
			logic [15:0] yi);
		int g;
		g = gap_len();
		repeat (g) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {yi, yr, xi, xr};
		s_tuser  <= {6'd0, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(op, xr, xi, yr, yi);
		@(negedge clk);
	endtask

	// receiver stalls, result checks and the watchdog
	always @(negedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(0, 15) == 0) ? 1'b0 :
			($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata[15:0], m_tdata[31:16], m_tuser[1:0]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= Limit) begin
			$display("watchdog: no beat for %0d cycles", Limit);
			$display("[complex_mul_div_unit_top] ERROR");
			$finish;
		end
	end

	initial begin
		sb = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// extremes for every operation, zero divisors and the unused selector
		for (int op = 0; op < 4; op++) begin
			send(op[1:0], 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
			send(op[1:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send(op[1:0], 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
			send(op[1:0], 16'h1000, 16'h0000, 16'h0001, 16'h0000);
			send(op[1:0], 16'h0800, 16'hf800, 16'h1000, 16'hf000);
		end
		send(cmdu_pkg::FUNC_DIV, 16'hffff, 16'h0001, 16'hffff, 16'h0001);
		send(cmdu_pkg::FUNC_RECIP, 16'h1234, 16'h5678, 16'h8000, 16'h0000);
		for (int i = 0; i < 1150; i++) begin
			logic [15:0] yr, yi;
			yr = rnd_val();
			yi = rnd_val();
			if ($urandom_range(0, 40) == 0) begin
				yr = 0;
				yi = 0;
			end
			send(2'($urandom_range(0, 3)), rnd_val(), rnd_val(), yr, yi);
		end
		s_tvalid <= 1'b0;
		while (sb.want_st.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("checked %0d results: %0d saturated, %0d divide-by-zero",
			sb.checked, sb.sat_seen, sb.dz_seen);
		if (sb.errors == 0) begin
			$display("[complex_mul_div_unit_top] OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("[complex_mul_div_unit_top] ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
sv/cmdu_pkg.sv
sv/cmdu_front.sv
sv/cmdu_div_stage.sv
sv/cmdu_out.sv
sv/complex_mul_div_unit_top.sv
tb/tb_complex_mul_div_unit_top.sv
